// ===== hw/rtl/assert_macros.svh =====
// assertion helpers included by the checker file sm3_chk.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define SM3_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sm3 check failed");

// next-cycle implication, sampled on clock, off during reset
`define SM3_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sm3 check failed");

`endif

// ===== hw/rtl/sm3_pkg.sv =====
package sm3_pkg;

   localparam int WORD_W     = 32;
   localparam int NUM_IV     = 8;
   localparam int CSR_ADDR_W = 4;

   typedef logic [WORD_W-1:0] word_type;

   localparam word_type T_LOW    = 32'h79cc4519;
   localparam word_type T_HIGH   = 32'h7a879d8a;
   localparam word_type PAD_MARK = 32'h80000000;

   localparam word_type IV_RESET [NUM_IV] = '{
      32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
      32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
   };

   // window control from the sequencer
   typedef struct packed {
      logic     push;
      logic     expand;
      word_type push_word;
   } sched_ctrl_type;

   // round unit control from the sequencer
   typedef struct packed {
      logic       load;
      logic       step;
      logic [5:0] round;
   } round_ctrl_type;

   function automatic word_type rotl32(input word_type x, input logic [4:0] n);
      return (x << n) | (x >> (6'd32 - {1'b0, n}));
   endfunction

   function automatic word_type perm0(input word_type x);
      return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
   endfunction

   function automatic word_type perm1(input word_type x);
      return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
   endfunction

   // leading bytes kept for a partial last word
   function automatic word_type keep_mask(input logic [2:0] n);
      word_type m;
      case (n)
         3'd0:    m = 32'h00000000;
         3'd1:    m = 32'hff000000;
         3'd2:    m = 32'hffff0000;
         3'd3:    m = 32'hffffff00;
         default: m = 32'hffffffff;
      endcase
      return m;
   endfunction

endpackage

// ===== hw/rtl/sm3_channels.sv =====
interface sm3_req_if;
   logic                    valid;
   logic                    ready;
   logic [31:0]             message_word;
   logic [2:0]              valid_bytes;
   logic                    last_word;
   modport source (output valid, message_word, valid_bytes, last_word, input ready);
   modport sink   (input valid, message_word, valid_bytes, last_word, output ready);
endinterface

interface sm3_rsp_if;
   logic                    valid;
   logic                    ready;
   logic [31:0]             digest_word;
   logic [2:0]              word_index;
   logic                    last_of_digest;
   modport source (output valid, digest_word, word_index, last_of_digest, input ready);
   modport sink   (input valid, digest_word, word_index, last_of_digest, output ready);
endinterface

interface sm3_csr_if;
   logic                            valid;
   logic                            ready;
   logic [sm3_pkg::CSR_ADDR_W-1:0]  reg_index;
   logic [31:0]                     wr_data;
   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ===== hw/rtl/sm3_sched.sv =====
module sm3_sched (
   input  logic                    clock,
   input  sm3_pkg::sched_ctrl_type ctrl,
   output sm3_pkg::word_type       w_cur,
   output sm3_pkg::word_type       w_far
);
   import sm3_pkg::*;

   word_type win_ff [16];
   word_type win_in [16];
   word_type expand_word;

   // next schedule word from the sliding window
   assign expand_word = perm1(win_ff[0] ^ win_ff[7] ^ rotl32(win_ff[13], 5'd15))
                        ^ rotl32(win_ff[3], 5'd7) ^ win_ff[10];

   // shift in a message word or an expanded word
   always_comb begin
      for (int i = 0; i < 16; i++) win_in[i] = win_ff[i];
      if (ctrl.push || ctrl.expand) begin
         for (int i = 0; i < 15; i++) win_in[i] = win_ff[i+1];
         win_in[15] = ctrl.expand ? expand_word : ctrl.push_word;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 16; i++) win_ff[i] <= win_in[i];
   end

   assign w_cur = win_ff[0];
   assign w_far = win_ff[4];

endmodule

// ===== hw/rtl/sm3_round.sv =====
module sm3_round (
   input  logic                    clock,
   input  sm3_pkg::round_ctrl_type ctrl,
   input  sm3_pkg::word_type       chain [8],
   input  sm3_pkg::word_type       w_cur,
   input  sm3_pkg::word_type       w_far,
   output sm3_pkg::word_type       work [8]
);
   import sm3_pkg::*;

   word_type work_ff [8];
   word_type work_in [8];
   word_type tj, a12, ss1, ss2, ffv, ggv, tt1, tt2;
   logic     early;

   // one compression round
   always_comb begin
      early = (ctrl.round < 6'd16);
      tj    = early ? T_LOW : T_HIGH;
      a12   = rotl32(work_ff[0], 5'd12);
      ss1   = rotl32(a12 + work_ff[4] + rotl32(tj, ctrl.round[4:0]), 5'd7);
      ss2   = ss1 ^ a12;
      ffv   = early ? (work_ff[0] ^ work_ff[1] ^ work_ff[2])
                    : ((work_ff[0] & work_ff[1]) | (work_ff[0] & work_ff[2])
                       | (work_ff[1] & work_ff[2]));
      ggv   = early ? (work_ff[4] ^ work_ff[5] ^ work_ff[6])
                    : ((work_ff[4] & work_ff[5]) | (~work_ff[4] & work_ff[6]));
      tt1   = ffv + work_ff[3] + ss2 + (w_cur ^ w_far);
      tt2   = ggv + work_ff[7] + ss1 + w_cur;
   end

   // load from chain value or advance one round
   always_comb begin
      for (int i = 0; i < 8; i++) work_in[i] = work_ff[i];
      if (ctrl.load) begin
         for (int i = 0; i < 8; i++) work_in[i] = chain[i];
      end else if (ctrl.step) begin
         work_in[0] = tt1;
         work_in[1] = work_ff[0];
         work_in[2] = rotl32(work_ff[1], 5'd9);
         work_in[3] = work_ff[2];
         work_in[4] = perm0(tt2);
         work_in[5] = work_ff[4];
         work_in[6] = rotl32(work_ff[5], 5'd19);
         work_in[7] = work_ff[6];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 8; i++) work_ff[i] <= work_in[i];
   end

   assign work = work_ff;

endmodule

// ===== hw/rtl/sm3_hash_core_unit.sv =====
// channel   dir  payload                                     moves
// req_ch    in   message_word, valid_bytes, last_word        one message word
// rsp_ch    out  digest_word, word_index, last_of_digest     one digest word
// csr_ch    in   reg_index, wr_data                          one iv register
//
// a word closing a 16-word block runs 64 rounds of the shared round unit
// and then a fold. a last word adds up to 18 padding words and the rounds
// and fold of any extra block, then 8 digest words.
// reset is synchronous, restores the standard iv and empties the message.
// req_ch is not ready while rounds, padding or digest delivery are running;
// a stalled rsp_ch holds the current digest word.
module sm3_hash_core_unit (
   input  logic  clock,
   input  logic  reset,
   sm3_req_if.sink   req_ch,
   sm3_rsp_if.source rsp_ch,
   sm3_csr_if.sink   csr_ch
);
   import sm3_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ROUND = 3'd1;
   localparam logic [2:0] ST_FOLD  = 3'd2;
   localparam logic [2:0] ST_PAD   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0]  state_ff, state_in;
   word_type    iv_ff [NUM_IV];
   word_type    chain_ff [8], chain_in [8];
   logic [63:0] bitlen_ff, bitlen_in;
   logic [3:0]  pos_ff, pos_in;
   logic [5:0]  round_ff, round_in;
   logic        open_ff, open_in;
   logic        marker_ff, marker_in;
   logic        hi_sent_ff, hi_sent_in;
   logic        ending_ff, ending_in;
   logic        padding_ff, padding_in;
   logic [2:0]  idx_ff, idx_in;

   logic           req_take, rsp_take, csr_take;
   logic [2:0]     nb;
   logic           push_en;
   word_type       push_val;
   sched_ctrl_type sctrl;
   round_ctrl_type rctrl;
   word_type       w_cur, w_far;
   word_type       work [8];

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign rsp_take     = rsp_ch.valid && rsp_ch.ready;
   assign csr_take     = csr_ch.valid && csr_ch.ready;
   assign nb           = (req_ch.valid_bytes > 3'd4) ? 3'd4 : req_ch.valid_bytes;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      for (int i = 0; i < 8; i++) chain_in[i] = chain_ff[i];
      bitlen_in  = bitlen_ff;
      pos_in     = pos_ff;
      round_in   = round_ff;
      open_in    = open_ff;
      marker_in  = marker_ff;
      hi_sent_in = hi_sent_ff;
      ending_in  = ending_ff;
      padding_in = padding_ff;
      idx_in     = idx_ff;
      push_en    = 1'b0;
      push_val   = '0;
      rctrl      = '{load: 1'b0, step: 1'b0, round: round_ff};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               push_en = 1'b1;
               open_in = 1'b1;
               if (!open_ff) begin
                  for (int i = 0; i < 8; i++) chain_in[i] = iv_ff[i];
               end
               if (!req_ch.last_word) begin
                  bitlen_in = bitlen_ff + 64'd32;
                  push_val  = req_ch.message_word;
               end else begin
                  bitlen_in  = bitlen_ff + {58'd0, nb, 3'b000};
                  padding_in = 1'b1;
                  hi_sent_in = 1'b0;
                  if (nb == 3'd4) begin
                     push_val  = req_ch.message_word;
                     marker_in = 1'b1;
                  end else begin
                     push_val  = (req_ch.message_word & keep_mask(nb))
                                 | (PAD_MARK >> {nb, 3'b000});
                     marker_in = 1'b0;
                  end
               end
            end
         end
         ST_PAD: begin
            push_en = 1'b1;
            if (marker_ff) begin
               push_val  = PAD_MARK;
               marker_in = 1'b0;
            end else if (pos_ff == 4'd14) begin
               push_val   = bitlen_ff[63:32];
               hi_sent_in = 1'b1;
            end else if (pos_ff == 4'd15 && hi_sent_ff) begin
               push_val  = bitlen_ff[31:0];
               ending_in = 1'b1;
            end else begin
               push_val = '0;
            end
         end
         ST_ROUND: begin
            rctrl.step = 1'b1;
            round_in   = round_ff + 6'd1;
            if (round_ff == 6'd63) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            for (int i = 0; i < 8; i++) chain_in[i] = chain_ff[i] ^ work[i];
            idx_in = '0;
            if (ending_ff)       state_in = ST_OUT;
            else if (padding_ff) state_in = ST_PAD;
            else                 state_in = ST_IDLE;
         end
         ST_OUT: begin
            if (rsp_take) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  state_in   = ST_IDLE;
                  open_in    = 1'b0;
                  padding_in = 1'b0;
                  ending_in  = 1'b0;
                  bitlen_in  = '0;
                  pos_in     = '0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // word into the window, block full starts the rounds
      if (push_en) begin
         if (pos_ff == 4'd15) begin
            pos_in     = '0;
            rctrl.load = 1'b1;
            round_in   = '0;
            state_in   = ST_ROUND;
         end else begin
            pos_in   = pos_ff + 4'd1;
            state_in = padding_in ? ST_PAD : ST_IDLE;
         end
      end
   end

   always_comb begin
      sctrl.push      = push_en;
      sctrl.expand    = (state_ff == ST_ROUND);
      sctrl.push_word = push_val;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bitlen_ff  <= '0;
         pos_ff     <= '0;
         round_ff   <= '0;
         open_ff    <= 1'b0;
         marker_ff  <= 1'b0;
         hi_sent_ff <= 1'b0;
         ending_ff  <= 1'b0;
         padding_ff <= 1'b0;
         idx_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         bitlen_ff  <= bitlen_in;
         pos_ff     <= pos_in;
         round_ff   <= round_in;
         open_ff    <= open_in;
         marker_ff  <= marker_in;
         hi_sent_ff <= hi_sent_in;
         ending_ff  <= ending_in;
         padding_ff <= padding_in;
         idx_ff     <= idx_in;
      end
   end

   // chain value
   always_ff @(posedge clock) begin
      for (int i = 0; i < 8; i++) chain_ff[i] <= chain_in[i];
   end

   // iv registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_IV; i++) iv_ff[i] <= IV_RESET[i];
      end else if (csr_take && csr_ch.reg_index < CSR_ADDR_W'(NUM_IV)) begin
         iv_ff[csr_ch.reg_index[2:0]] <= csr_ch.wr_data;
      end
   end

   sm3_sched u_sched (
      .clock (clock),
      .ctrl  (sctrl),
      .w_cur (w_cur),
      .w_far (w_far)
   );

   sm3_round u_round (
      .clock (clock),
      .ctrl  (rctrl),
      .chain (chain_ff),
      .w_cur (w_cur),
      .w_far (w_far),
      .work  (work)
   );

   // digest output
   assign rsp_ch.valid          = (state_ff == ST_OUT);
   assign rsp_ch.digest_word    = chain_ff[idx_ff];
   assign rsp_ch.word_index     = idx_ff;
   assign rsp_ch.last_of_digest = (idx_ff == 3'd7);

endmodule

// ===== hw/rtl/sm3_chk.sv =====
`include "assert_macros.svh"

module sm3_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] digest_word,
   input logic [2:0]  word_index,
   input logic        last_of_digest
);

   // no new request while a digest is being delivered
   `SM3_ASSERT_NOW(a_busy_out, rsp_valid, !req_ready)

   // digest words come in index order
   `SM3_ASSERT_NEXT(a_idx_step, rsp_valid && rsp_ready && !last_of_digest, rsp_valid && word_index == $past(word_index) + 3'd1)

   // the eighth word ends the digest
   `SM3_ASSERT_NEXT(a_end, rsp_valid && rsp_ready && last_of_digest, !rsp_valid && req_ready)

   // stalled digest word holds
   `SM3_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(digest_word) && $stable(word_index))

endmodule

bind sm3_hash_core_unit sm3_chk u_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .digest_word    (rsp_ch.digest_word),
   .word_index     (rsp_ch.word_index),
   .last_of_digest (rsp_ch.last_of_digest)
);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import sm3_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 220;
   localparam logic [CSR_ADDR_W-1:0] IV_WORD0 = '0;

   typedef struct {
      logic [31:0] data;
      logic [2:0]  nbytes;
      logic        last;
   } msg_word_type;

   typedef struct {
      logic [31:0] data;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sm3_req_if req_ch ();
   sm3_rsp_if rsp_ch ();
   sm3_csr_if csr_ch ();

   sm3_hash_core_unit uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source),
      .csr_ch(csr_ch.sink)
   );

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   msg_word_type    pending_words[$];
   digest_word_type expected_digest[$];
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_until = 0;
   int  mismatches = 0;
   int  cycles = 0;
   bit  req_taken = 1'b0;

   // digest model state
   word_type    iv_model[NUM_IV];
   word_type    chain[8];
   word_type    window[16];
   logic [63:0] bit_count;
   int          fill;
   bit          msg_open;

   function automatic word_type rol(word_type x, int n);
      n = n % 32;
      if (n == 0) return x;
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic word_type p0(word_type x);
      return x ^ rol(x, 9) ^ rol(x, 17);
   endfunction

   function automatic word_type p1(word_type x);
      return x ^ rol(x, 15) ^ rol(x, 23);
   endfunction

   task automatic compress();
      word_type x[68];
      word_type v[8];
      word_type t, a12, ss1, ss2, ff, gg, tt1, tt2;
      for (int i = 0; i < 16; i++) x[i] = window[i];
      for (int i = 16; i < 68; i++)
         x[i] = p1(x[i-16] ^ x[i-9] ^ rol(x[i-3], 15)) ^ rol(x[i-13], 7) ^ x[i-6];
      v = chain;
      for (int j = 0; j < 64; j++) begin
         t   = (j < 16) ? T_LOW : T_HIGH;
         a12 = rol(v[0], 12);
         ss1 = rol(a12 + v[4] + rol(t, j), 7);
         ss2 = ss1 ^ a12;
         ff  = (j < 16) ? (v[0] ^ v[1] ^ v[2])
                        : ((v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]));
         gg  = (j < 16) ? (v[4] ^ v[5] ^ v[6]) : ((v[4] & v[5]) | (~v[4] & v[6]));
         tt1 = ff + v[3] + ss2 + (x[j] ^ x[j+4]);
         tt2 = gg + v[7] + ss1 + x[j];
         v[3] = v[2]; v[2] = rol(v[1], 9); v[1] = v[0]; v[0] = tt1;
         v[7] = v[6]; v[6] = rol(v[5], 19); v[5] = v[4]; v[4] = p0(tt2);
      end
      for (int i = 0; i < 8; i++) chain[i] ^= v[i];
   endtask

   task automatic absorb(word_type w);
      window[fill] = w;
      fill++;
      if (fill == 16) begin
         compress();
         fill = 0;
      end
   endtask

   // advance the digest model by one accepted request
   task automatic hash_word(msg_word_type m);
      int n;
      digest_word_type d;
      if (!msg_open) begin
         chain = iv_model;
         bit_count = '0;
         fill = 0;
         msg_open = 1'b1;
      end
      if (!m.last) begin
         bit_count += 64'd32;
         absorb(m.data);
         return;
      end
      n = (m.nbytes > 4) ? 4 : m.nbytes;
      bit_count += 64'(8 * n);
      if (n == 4) begin
         absorb(m.data);
         absorb(PAD_MARK);
      end else begin
         absorb((m.data & keep_mask(3'(n))) | (32'h80 << (24 - 8 * n)));
      end
      while (fill != 14) absorb('0);
      absorb(bit_count[63:32]);
      absorb(bit_count[31:0]);
      for (int i = 0; i < 8; i++) begin
         d.data = chain[i];
         d.index = 3'(i);
         d.last = (i == 7);
         expected_digest.push_back(d);
      end
      msg_open = 1'b0;
   endtask

   // request driver
   always @(negedge clock) begin
      msg_word_type m;
      if (reset) begin
         req_ch.valid        <= 1'b0;
         req_ch.message_word <= '0;
         req_ch.valid_bytes  <= '0;
         req_ch.last_word    <= 1'b0;
      end else if (!(req_ch.valid && !req_taken)) begin
         if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            m = pending_words.pop_front();
            req_ch.valid        <= 1'b1;
            req_ch.message_word <= m.data;
            req_ch.valid_bytes  <= m.nbytes;
            req_ch.last_word    <= m.last;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response ready, with random stalls and the long hold-off
   always @(negedge clock) begin
      if (cycles < hold_until) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor: predict on accepted requests, check accepted digest words
   always @(posedge clock) begin
      msg_word_type m;
      digest_word_type e;
      cycles++;
      req_taken = 1'b0;
      if (!reset && req_ch.valid && req_ch.ready) begin
         req_taken = 1'b1;
         m.data = req_ch.message_word;
         m.nbytes = req_ch.valid_bytes;
         m.last = req_ch.last_word;
         hash_word(m);
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_digest.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected digest word %h index %0d", rsp_ch.digest_word,
                        rsp_ch.word_index);
         end else begin
            e = expected_digest.pop_front();
            if (rsp_ch.digest_word !== e.data || rsp_ch.word_index !== e.index ||
                rsp_ch.last_of_digest !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                           e.data, e.index, e.last, rsp_ch.digest_word,
                           rsp_ch.word_index, rsp_ch.last_of_digest);
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic queue_word(logic [31:0] data, logic [2:0] nbytes, logic last);
      msg_word_type m;
      m.data = data;
      m.nbytes = nbytes;
      m.last = last;
      pending_words.push_back(m);
   endtask

   // one message of full words closed by a random last word
   task automatic queue_message(int full_words);
      for (int i = 0; i < full_words; i++)
         queue_word($urandom, 3'($urandom_range(7)), 1'b0);
      queue_word($urandom, 3'($urandom_range(7)), 1'b1);
   endtask

   task automatic wait_idle();
      while (pending_words.size() > 0 || req_ch.valid || expected_digest.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_iv(int i, word_type value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.reg_index <= IV_WORD0 + CSR_ADDR_W'(i);
      csr_ch.wr_data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      iv_model[i] = value;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      int msgs;
      csr_ch.valid = 1'b0;
      csr_ch.reg_index = '0;
      csr_ch.wr_data = '0;
      iv_model = IV_RESET;
      chain = IV_RESET;
      bit_count = '0;
      fill = 0;
      msg_open = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty and partial last words, saturated counts, block spill
      queue_word(32'h00000000, 3'd0, 1'b1);
      queue_word(32'hffffffff, 3'd1, 1'b1);
      queue_word(32'hffffffff, 3'd2, 1'b1);
      queue_word(32'h61626300, 3'd3, 1'b1);
      queue_word(32'hffffffff, 3'd4, 1'b1);
      queue_word(32'h12345678, 3'd5, 1'b1);
      queue_word(32'h9abcdef0, 3'd6, 1'b1);
      queue_word(32'hffffffff, 3'd7, 1'b1);
      for (int i = 0; i < 13; i++) queue_word(i[0] ? '1 : '0, 3'(i % 8), 1'b0);
      queue_word(32'h55aa55aa, 3'd4, 1'b1);
      queue_word(32'haaaaaaaa, 3'd0, 1'b0);
      queue_word(32'h00000000, 3'd0, 1'b1);
      wait_idle();

      // random phases with different iv settings and flow-control modes
      for (int phase = 0; phase < 4; phase++) begin
         for (int i = 0; i < NUM_IV; i++)
            case (phase)
               0: write_iv(i, '0);
               1: write_iv(i, '1);
               2: write_iv(i, $urandom);
               default: write_iv(i, IV_RESET[i]);
            endcase
         send_idle_pct  = (phase == 1 || phase == 3) ? 64 : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 3 ? 36 : 64) : 0;
         if (phase == 3) send_idle_pct = 36;
         msgs = 0;
         while (msgs < 3) begin
            if ($urandom_range(9) == 0) queue_message($urandom_range(14, 33));
            else queue_message($urandom_range(0, 9));
            msgs++;
         end
         if (phase == 0) begin
            // receiver holds off while requests keep coming
            hold_until = cycles + 600;
            queue_message(3);
            queue_message(0);
            queue_message(20);
         end
         if (phase == 2) begin
            // sender waits for every outstanding digest before the next message
            while (pending_words.size() > 0 || req_ch.valid || expected_digest.size() > 0)
               @(posedge clock);
            queue_message($urandom_range(0, 16));
         end
         wait_idle();
      end

      if (mismatches == 0 && expected_digest.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/sm3_pkg.sv
hw/rtl/sm3_channels.sv
hw/rtl/sm3_sched.sv
hw/rtl/sm3_round.sv
hw/rtl/sm3_hash_core_unit.sv
hw/rtl/sm3_chk.sv
dv/tb.sv
